/* rtl/rtq_pkg.sv */
package rtq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;

  // clamped candidate width (unsigned), signed raw width
  localparam int TU_W = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
  localparam int TS_W = TU_W + 1;

  // first root: radicand t << FRAC_BITS, padded to an even width
  localparam int MX0_W  = TU_W + FRAC_BITS;
  localparam int M_IN_W = MX0_W + (MX0_W % 2);
  localparam int M_W    = M_IN_W / 2;
  localparam int RM_W   = M_W + 2;

  // norm root: sum of four squares
  localparam int SS_W = 2 * M_W + 2;
  localparam int N_W  = SS_W / 2;
  localparam int RN_W = N_W + 2;

  // normalize divide
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int NUM_W  = M_W + FRAC_BITS + 1;
  localparam int MAGC_W = (Q_W > OUT_W) ? Q_W : OUT_W;
  localparam logic [MAGC_W-1:0] SAT_MAX = MAGC_W'(32767);

  localparam int LANES = 4;

  typedef struct packed {
    logic signed [IN_W-1:0] a33;
    logic signed [IN_W-1:0] a32;
    logic signed [IN_W-1:0] a31;
    logic signed [IN_W-1:0] a23;
    logic signed [IN_W-1:0] a22;
    logic signed [IN_W-1:0] a21;
    logic signed [IN_W-1:0] a13;
    logic signed [IN_W-1:0] a12;
    logic signed [IN_W-1:0] a11;
  } mat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] quat_z;
    logic signed [OUT_W-1:0] quat_y;
    logic signed [OUT_W-1:0] quat_x;
    logic signed [OUT_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic [RM_W-1:0] rem;
    logic [M_W-1:0]  root;
  } sqm_t;

  typedef struct packed {
    logic [RN_W-1:0] rem;
    logic [N_W-1:0]  root;
  } sqn_t;

  typedef struct packed {
    logic [N_W-1:0] rem;
    logic [Q_W-1:0] quo;
  } div_t;

  function automatic sqm_t sqm_step(sqm_t s, logic [1:0] d);
    logic [RM_W-1:0] r2;
    logic [RM_W-1:0] tr;
    sqm_t o;
    r2 = {s.rem[RM_W-3:0], d};
    tr = {s.root, 2'b01};
    if (r2 >= tr) begin
      o.rem  = r2 - tr;
      o.root = {s.root[M_W-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[M_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sqn_t sqn_step(sqn_t s, logic [1:0] d);
    logic [RN_W-1:0] r2;
    logic [RN_W-1:0] tr;
    sqn_t o;
    r2 = {s.rem[RN_W-3:0], d};
    tr = {s.root, 2'b01};
    if (r2 >= tr) begin
      o.rem  = r2 - tr;
      o.root = {s.root[N_W-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[N_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // restoring divide step; remainder always below the divisor
  function automatic div_t div_step(div_t s, logic [N_W-1:0] n);
    logic [N_W:0] r2;
    logic ge;
    div_t o;
    r2 = {s.rem, s.quo[Q_W-1]};
    ge = (r2 >= {1'b0, n});
    o.rem = ge ? N_W'(r2 - {1'b0, n}) : N_W'(r2);
    o.quo = {s.quo[Q_W-2:0], ge};
    return o;
  endfunction

endpackage

/* rtl/rotmat_to_quaternion_top.sv */
// Channel  Dir  Ports                          Item
// in       in   in_tvalid/in_tready/in_tdata   one 3x3 rotation matrix, Q2.14
// out      out  out_tvalid/out_tready/out_tdata one quaternion w,x,y,z, Q2.14
//
// One matrix per cycle while out_tready does not stall the output; the path has
// 54 register stages: two setup stages, a 16-stage and a 17-stage
// bit-per-stage square root, a square and a sum stage, a divide load stage and
// 15 restoring divide steps, one output register.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
// A stall on out_tready lands the next item in a one-entry skid, which then
// freezes the pipeline; in_tready is registered and nothing is dropped.
module rotmat_to_quaternion_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a11, a12, a13, a21, a22, a23, a31, a32, a33 (16 bits each, lowest first)
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // quat_w, quat_x, quat_y, quat_z (16 bits each, lowest first)
  output logic [63:0]  out_tdata
);
  import rtq_pkg::*;

  mat_t  mat;
  quat_t core_q;
  logic  core_v;
  logic  en;

  quat_t out_d_r, sk_d_r;
  logic  out_valid_r, sk_valid_r;

  assign mat       = mat_t'(in_tdata);
  assign en        = !sk_valid_r;
  assign in_tready = en;

  rtq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid && in_tready),
    .in_mat    (mat),
    .out_valid (core_v),
    .out_quat  (core_q)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (sk_valid_r) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= 1'b0;
      end else begin
        out_valid_r <= core_v;
      end
    end else if (core_v && en) begin
      sk_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_d_r <= sk_valid_r ? sk_d_r : core_q;
    end else if (core_v && en) begin
      sk_d_r <= core_q;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_d_r.quat_z, out_d_r.quat_y, out_d_r.quat_x, out_d_r.quat_w};

`ifndef SYNTH
  a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> out_valid_r)
    else $error("skid holds an item while the output register is empty");

  a_skid_fill_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid filled without an output stall");

  a_skid_drain : assert property (@(posedge clk) disable iff (!rst_n)
    (sk_valid_r && out_tready) |=> (out_valid_r && !sk_valid_r))
    else $error("skid item not moved to the output register");
`endif

endmodule

/* rtl/rtq_core.sv */
module rtq_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  rtq_pkg::mat_t in_mat,
  output logic          out_valid,
  output rtq_pkg::quat_t out_quat
);
  import rtq_pkg::*;

  localparam logic signed [TS_W-1:0] ONE_T = TS_W'(1) << FRAC_BITS;

  // stage 1: candidates and off-diagonal signs
  logic signed [TS_W-1:0] tr_nxt [LANES];
  logic signed [TS_W-1:0] t_r [LANES];
  logic [5:0] neg_nxt, neg_r;
  logic v1_r;

  function automatic logic signed [TS_W-1:0] sx(logic signed [IN_W-1:0] v);
    return TS_W'(v);
  endfunction

  function automatic logic negd(logic signed [IN_W-1:0] a, logic signed [IN_W-1:0] b,
                                logic sub);
    logic signed [IN_W:0] r;
    r = sub ? ((IN_W+1)'(a) - (IN_W+1)'(b)) : ((IN_W+1)'(a) + (IN_W+1)'(b));
    return r[IN_W];
  endfunction

  always_comb begin
    tr_nxt[0] =  sx(in_mat.a11) + sx(in_mat.a22) + sx(in_mat.a33) + ONE_T;
    tr_nxt[1] =  sx(in_mat.a11) - sx(in_mat.a22) - sx(in_mat.a33) + ONE_T;
    tr_nxt[2] = -sx(in_mat.a11) + sx(in_mat.a22) - sx(in_mat.a33) + ONE_T;
    tr_nxt[3] = -sx(in_mat.a11) - sx(in_mat.a22) + sx(in_mat.a33) + ONE_T;
    // 0: a32-a23  1: a13-a31  2: a21-a12  3: a21+a12  4: a13+a31  5: a32+a23
    neg_nxt[0] = negd(in_mat.a32, in_mat.a23, 1'b1);
    neg_nxt[1] = negd(in_mat.a13, in_mat.a31, 1'b1);
    neg_nxt[2] = negd(in_mat.a21, in_mat.a12, 1'b1);
    neg_nxt[3] = negd(in_mat.a21, in_mat.a12, 1'b0);
    neg_nxt[4] = negd(in_mat.a13, in_mat.a31, 1'b0);
    neg_nxt[5] = negd(in_mat.a32, in_mat.a23, 1'b0);
  end

  // stage 2: clamp, pick reference, select signs
  logic [TU_W-1:0] tu [LANES];
  logic [1:0] k;
  logic [3:0] sg_nxt;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      tu[l] = t_r[l][TS_W-1] ? '0 : t_r[l][TU_W-1:0];
    end
    k = 2'd0;
    for (int j = 1; j < LANES; j++) begin
      if (tu[j] > tu[k]) k = 2'(j);
    end
    case (k)
      2'd0:    sg_nxt = {neg_r[2], neg_r[1], neg_r[0], 1'b0};
      2'd1:    sg_nxt = {neg_r[4], neg_r[3], 1'b0, neg_r[0]};
      2'd2:    sg_nxt = {neg_r[5], 1'b0, neg_r[3], neg_r[1]};
      default: sg_nxt = {1'b0, neg_r[5], neg_r[4], neg_r[2]};
    endcase
  end

  // magnitude roots, one result bit per stage
  logic [M_IN_W-1:0] ax_r [M_W][LANES];
  sqm_t              am_r [M_W+1][LANES];
  logic [3:0]        asg_r [M_W+1];
  logic              av_r [M_W+1];

  // squares
  logic [2*M_W-1:0] sq_r [LANES];
  logic [M_W-1:0]   qm_r [LANES];
  logic [3:0]       qsg_r;
  logic             qv_r;

  // norm root
  logic [SS_W-1:0] bx_r [N_W];
  sqn_t            bn_r [N_W+1];
  logic [M_W-1:0]  bm_r [N_W+1][LANES];
  logic [3:0]      bsg_r [N_W+1];
  logic            bv_r [N_W+1];

  // divide
  logic [NUM_W-1:0] num [LANES];
  div_t             cd_r [Q_W+1][LANES];
  logic [N_W-1:0]   cn_r [Q_W+1];
  logic [3:0]       csg_r [Q_W+1];
  logic             cv_r [Q_W+1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num[l] = (NUM_W'(bm_r[N_W][l]) << FRAC_BITS) + NUM_W'(bn_r[N_W].root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      qv_r <= 1'b0;
      for (int s = 0; s <= M_W; s++) av_r[s] <= 1'b0;
      for (int s = 0; s <= N_W; s++) bv_r[s] <= 1'b0;
      for (int s = 0; s <= Q_W; s++) cv_r[s] <= 1'b0;
    end else if (en) begin
      v1_r    <= in_valid;
      av_r[0] <= v1_r;
      for (int s = 0; s < M_W; s++) av_r[s+1] <= av_r[s];
      qv_r    <= av_r[M_W];
      bv_r[0] <= qv_r;
      for (int s = 0; s < N_W; s++) bv_r[s+1] <= bv_r[s];
      cv_r[0] <= bv_r[N_W];
      for (int s = 0; s < Q_W; s++) cv_r[s+1] <= cv_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r   <= tr_nxt;
      neg_r <= neg_nxt;

      asg_r[0] <= sg_nxt;
      for (int l = 0; l < LANES; l++) begin
        ax_r[0][l] <= M_IN_W'(tu[l]) << FRAC_BITS;
        am_r[0][l] <= '0;
      end
      for (int s = 0; s < M_W; s++) begin
        asg_r[s+1] <= asg_r[s];
        for (int l = 0; l < LANES; l++) begin
          am_r[s+1][l] <= sqm_step(am_r[s][l], ax_r[s][l][M_IN_W-1 -: 2]);
          if (s + 1 < M_W) ax_r[s+1][l] <= ax_r[s][l] << 2;
        end
      end

      qsg_r <= asg_r[M_W];
      for (int l = 0; l < LANES; l++) begin
        qm_r[l] <= am_r[M_W][l].root;
        sq_r[l] <= (2*M_W)'(am_r[M_W][l].root) * (2*M_W)'(am_r[M_W][l].root);
      end

      bx_r[0]  <= SS_W'(sq_r[0]) + SS_W'(sq_r[1]) + SS_W'(sq_r[2]) + SS_W'(sq_r[3]);
      bn_r[0]  <= '0;
      bsg_r[0] <= qsg_r;
      bm_r[0]  <= qm_r;
      for (int s = 0; s < N_W; s++) begin
        bn_r[s+1]  <= sqn_step(bn_r[s], bx_r[s][SS_W-1 -: 2]);
        bsg_r[s+1] <= bsg_r[s];
        bm_r[s+1]  <= bm_r[s];
        if (s + 1 < N_W) bx_r[s+1] <= bx_r[s] << 2;
      end

      cn_r[0]  <= bn_r[N_W].root;
      csg_r[0] <= bsg_r[N_W];
      for (int l = 0; l < LANES; l++) begin
        cd_r[0][l].rem <= N_W'(num[l] >> Q_W);
        cd_r[0][l].quo <= num[l][Q_W-1:0];
      end
      for (int s = 0; s < Q_W; s++) begin
        cn_r[s+1]  <= cn_r[s];
        csg_r[s+1] <= csg_r[s];
        for (int l = 0; l < LANES; l++) begin
          cd_r[s+1][l] <= div_step(cd_r[s][l], cn_r[s]);
        end
      end
    end
  end

  // saturate, force zero on a zero norm, and apply signs
  logic [OUT_W-1:0] res [LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [MAGC_W-1:0] mc;
      logic [OUT_W-1:0]  mag;
      mc  = (cn_r[Q_W] == '0) ? '0 : MAGC_W'(cd_r[Q_W][l].quo);
      mag = (mc > SAT_MAX) ? OUT_W'(SAT_MAX) : OUT_W'(mc);
      res[l] = csg_r[Q_W][l] ? (OUT_W'(0) - mag) : mag;
    end
  end

  assign out_valid       = cv_r[Q_W];
  assign out_quat.quat_w = res[0];
  assign out_quat.quat_x = res[1];
  assign out_quat.quat_y = res[2];
  assign out_quat.quat_z = res[3];

endmodule
